// ===== rtl/core/aht_pkg.sv =====
// Package: shared types, constants and hash function for the allocation table.
`default_nettype none
package aht_pkg;
   localparam int SLOTS     = 2048;   // power of two
   localparam int SITE_BITS = 16;
   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int LIVE_W    = 12;
   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      STATUS_RECORDED = 3'd0,
      STATUS_DROPPED  = 3'd1,
      STATUS_LOST     = 3'd2,
      STATUS_UNKNOWN  = 3'd3,
      STATUS_NULL     = 3'd4
   } status_type;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_DROP   = 1'b1
   } op_type;

   typedef struct packed {
      logic [31:0]          addr;
      logic [31:0]          size;
      logic [SITE_BITS-1:0] site;
   } aht_entry_type;

   localparam int ENTRY_W = $bits(aht_entry_type);

   typedef struct packed {
      op_type               op;
      logic                 is_null;
      logic [31:0]          addr;
      logic [31:0]          size;
      logic [SITE_BITS-1:0] site;
      logic [IDX_W-1:0]     home;
   } aht_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PROBE_RD, ST_PROBE_CHK, ST_CLOSE_RD, ST_CLOSE_CHK,
      ST_MOVE_RD, ST_MOVE_CHK, ST_RESP
   } back_state_type;

   function automatic logic [IDX_W-1:0] home_of(input logic [31:0] addr);
      logic [31:0] prod;
      prod = 32'({3'b000, addr[31:3]} * HASH_MULT);
      return prod[IDX_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/aht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/aht_front.sv =====
// Front end: accepts requests, classifies them, hashes the home slot, queues them.
`default_nettype none
module aht_front import aht_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_type,
   input  wire logic [31:0]   req_block_addr,
   input  wire logic [31:0]   req_block_size,
   input  wire logic [15:0]   req_site_id,
   input  wire logic          clearing,
   output logic               item_valid,
   output aht_item_type       item,
   input  wire logic          item_pop
);
   aht_item_type q_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   aht_item_type new_item;
   logic         push;

   always_comb begin
      new_item.op      = op_type'(req_type);
      new_item.is_null = (req_block_addr == 32'd0);
      new_item.addr    = req_block_addr;
      new_item.size    = req_block_size;
      new_item.site    = SITE_BITS'(req_site_id);
      new_item.home    = home_of(req_block_addr);
   end

   assign req_stall  = (cnt_ff == 2'd2) || clearing;
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ item_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= new_item;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/aht_back.sv =====
// Back end: probe sequencer, hole closing after drops, counters, result register.
`default_nettype none
module aht_back import aht_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  aht_item_type             item,
   output logic                     item_pop,
   output logic                     clearing,
   output logic                     ram_wr_en,
   output logic [IDX_W-1:0]         ram_wr_addr,
   output aht_entry_type            ram_wr_data,
   output logic                     ram_rd_en,
   output logic [IDX_W-1:0]         ram_rd_addr,
   input  aht_entry_type            ram_rd_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [LIVE_W-1:0]        rsp_live_count,
   output logic [LIVE_W-1:0]        rsp_live_peak,
   output logic [31:0]              rsp_live_bytes,
   output logic [31:0]              rsp_lost_total,
   output logic [31:0]              rsp_unknown_total
);
   back_state_type state_ff, state_in;
   aht_item_type   cur_ff, cur_in;
   aht_entry_type  mv_ff, mv_in;
   logic [IDX_W-1:0] idx_ff, idx_in, j_ff, j_in;
   logic [CNT_W-1:0] n_ff, n_in, occ_ff, occ_in, peak_ff, peak_in;
   logic [31:0]    bytes_ff, bytes_in, lost_ff, lost_in, unk_ff, unk_in;
   status_type     stat_ff, stat_in;
   logic           rv_ff, rv_in, load_rsp;
   status_type     rs_ff;
   logic [LIVE_W-1:0] rc_ff, rp_ff;
   logic [31:0]    rb_ff, rl_ff, ru_ff;

   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      mv_in       = mv_ff;
      idx_in      = idx_ff;
      j_in        = j_ff;
      n_in        = n_ff;
      occ_in      = occ_ff;
      peak_in     = peak_ff;
      bytes_in    = bytes_ff;
      lost_in     = lost_ff;
      unk_in      = unk_ff;
      stat_in     = stat_ff;
      item_pop    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;
      load_rsp    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in   = item;
               idx_in   = item.home;
               n_in     = '0;
               if (item.is_null) begin
                  stat_in  = STATUS_NULL;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_PROBE_RD;
               end
            end
         end
         ST_PROBE_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_PROBE_CHK;
         end
         ST_PROBE_CHK: begin
            state_in = ST_PROBE_RD;
            idx_in   = idx_ff + 1'b1;
            n_in     = n_ff + 1'b1;
            if (cur_ff.op == OP_RECORD) begin
               if (ram_rd_data.addr == 32'd0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = '{addr: cur_ff.addr, size: cur_ff.size, site: cur_ff.site};
                  occ_in      = occ_ff + 1'b1;
                  if (occ_in > peak_ff) begin
                     peak_in = occ_in;
                  end
                  bytes_in = bytes_ff + cur_ff.size;
                  stat_in  = STATUS_RECORDED;
                  state_in = ST_RESP;
               end else if (n_ff == CNT_W'(SLOTS - 1)) begin
                  if (lost_ff != SAT32) begin
                     lost_in = lost_ff + 32'd1;
                  end
                  stat_in  = STATUS_LOST;
                  state_in = ST_RESP;
               end
            end else begin
               if (ram_rd_data.addr == cur_ff.addr) begin
                  ram_wr_en = 1'b1;
                  bytes_in  = bytes_ff - ram_rd_data.size;
                  if (occ_ff != '0) begin
                     occ_in = occ_ff - 1'b1;
                  end
                  stat_in  = STATUS_DROPPED;
                  j_in     = idx_ff + 1'b1;
                  n_in     = '0;
                  state_in = ST_CLOSE_RD;
               end else if (ram_rd_data.addr == 32'd0 || n_ff == CNT_W'(SLOTS - 1)) begin
                  if (unk_ff != SAT32) begin
                     unk_in = unk_ff + 32'd1;
                  end
                  stat_in  = STATUS_UNKNOWN;
                  state_in = ST_RESP;
               end
            end
         end
         ST_CLOSE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = j_ff;
            state_in    = ST_CLOSE_CHK;
         end
         ST_CLOSE_CHK: begin
            if (ram_rd_data.addr == 32'd0 || n_ff == CNT_W'(SLOTS)) begin
               state_in = ST_RESP;
            end else begin
               // lift the entry, then reinsert it from its own home
               mv_in       = ram_rd_data;
               ram_wr_en   = 1'b1;
               ram_wr_addr = j_ff;
               idx_in      = home_of(ram_rd_data.addr);
               state_in    = ST_MOVE_RD;
            end
         end
         ST_MOVE_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MOVE_CHK;
         end
         ST_MOVE_CHK: begin
            // always finds a slot: the lifted one is empty
            if (ram_rd_data.addr == 32'd0) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = mv_ff;
               j_in        = j_ff + 1'b1;
               n_in        = n_ff + 1'b1;
               state_in    = ST_CLOSE_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MOVE_RD;
            end
         end
         ST_RESP: begin
            if (!rv_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rv_in = load_rsp || (rv_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         occ_ff   <= '0;
         peak_ff  <= '0;
         bytes_ff <= '0;
         lost_ff  <= '0;
         unk_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         occ_ff   <= occ_in;
         peak_ff  <= peak_in;
         bytes_ff <= bytes_in;
         lost_ff  <= lost_in;
         unk_ff   <= unk_in;
         rv_ff    <= rv_in;
      end
      cur_ff  <= cur_in;
      mv_ff   <= mv_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      stat_ff <= stat_in;
      if (load_rsp) begin
         rs_ff <= stat_ff;
         rc_ff <= LIVE_W'(occ_ff);
         rp_ff <= LIVE_W'(peak_ff);
         rb_ff <= bytes_ff;
         rl_ff <= lost_ff;
         ru_ff <= unk_ff;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rs_ff;
   assign rsp_live_count    = rc_ff;
   assign rsp_live_peak     = rp_ff;
   assign rsp_live_bytes    = rb_ff;
   assign rsp_lost_total    = rl_ff;
   assign rsp_unknown_total = ru_ff;
endmodule
`default_nettype wire

// ===== rtl/core/alloc_tracking_hash_table_core.sv =====
// Allocation tracking hash table: top level.
//
// Request channel (req_*): record (req_type 0) or drop (req_type 1) of a block
// address; a transaction is taken when req_valid is high and req_stall low.
// Result channel (rsp_*): one result per request, in order, with a status and
// the live count, peak, byte total and saturating lost/unknown counters.
// A two-entry queue sits between the request front end and the probe engine.
// Each probed slot takes a read state and then a check state. A drop then walks
// the following run, lifting each entry and reinserting it by probing from its
// own home, until an empty slot ends the run; then the result is loaded. The
// engine takes the next request from the queue only after it has loaded the
// result of the last one; one request is in the engine at a time, limited by
// the single RAM read port.
// After reset the address store is swept to empty, one slot per cycle, across
// all 2048 slots; req_stall stays high during the sweep.
// When rsp_stall is high the result register holds; the engine finishes its
// current request and waits, and the queue keeps taking requests until full.
`default_nettype none
module alloc_tracking_hash_table_core import aht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [31:0] req_block_addr,
   input  wire logic [31:0] req_block_size,
   input  wire logic [15:0] req_site_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [11:0]      rsp_live_count,
   output logic [11:0]      rsp_live_peak,
   output logic [31:0]      rsp_live_bytes,
   output logic [31:0]      rsp_lost_total,
   output logic [31:0]      rsp_unknown_total
);
   logic             clearing, item_valid, item_pop;
   aht_item_type     item;
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   aht_entry_type    ram_wr_data, ram_rd_data;

   aht_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_block_addr,
      .req_block_size, .req_site_id, .clearing, .item_valid, .item, .item_pop
   );

   aht_back u_back (
      .clock, .reset, .item_valid, .item, .item_pop, .clearing,
      .ram_wr_en, .ram_wr_addr, .ram_wr_data, .ram_rd_en, .ram_rd_addr, .ram_rd_data,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_live_count, .rsp_live_peak,
      .rsp_live_bytes, .rsp_lost_total, .rsp_unknown_total
   );

   aht_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock, .wr_en(ram_wr_en), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
      .rd_en(ram_rd_en), .rd_addr(ram_rd_addr), .rd_data_ff(ram_rd_data)
   );

   a_count_le_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_live_count <= rsp_live_peak)
      else $error("live count above peak");

   a_no_take_while_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("request taken during clearing sweep");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_NULL)
      else $error("bad status code");
endmodule
`default_nettype wire
